FILE: src/morse_pkg.sv
package morse_pkg;

  localparam int unsigned MaxSymbols = 6;
  localparam int unsigned LenWidth   = 3;
  localparam int unsigned PatWidth   = 7;
  localparam logic [7:0]  FoldOffset = 8'd32;

  localparam logic [1:0] SymDot  = 2'd0;
  localparam logic [1:0] SymDash = 2'd1;
  localparam logic [1:0] SymGap  = 2'd2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_message;
  } morse_in_t;

  typedef struct packed {
    logic [1:0] symbol;
    logic       unsupported;
    logic       last_of_char;
  } morse_out_t;

  // One classified character: symbols in emission order, first one in bit 0.
  typedef struct packed {
    logic                  unsupported;
    logic [LenWidth-1:0]   len;
    logic [MaxSymbols-1:0] syms;
  } morse_entry_t;

  // Returns the marker-prefixed pattern, or zero for a character outside the code.
  function automatic logic [PatWidth-1:0] morse_lookup(input logic [7:0] ch);
    logic [PatWidth-1:0] pat;
    pat = '0;
    unique case (ch)
      8'h41: pat = 7'd5;
      8'h42: pat = 7'd24;
      8'h43: pat = 7'd26;
      8'h44: pat = 7'd12;
      8'h45: pat = 7'd2;
      8'h46: pat = 7'd18;
      8'h47: pat = 7'd14;
      8'h48: pat = 7'd16;
      8'h49: pat = 7'd4;
      8'h4A: pat = 7'd23;
      8'h4B: pat = 7'd13;
      8'h4C: pat = 7'd20;
      8'h4D: pat = 7'd7;
      8'h4E: pat = 7'd6;
      8'h4F: pat = 7'd15;
      8'h50: pat = 7'd22;
      8'h51: pat = 7'd29;
      8'h52: pat = 7'd10;
      8'h53: pat = 7'd8;
      8'h54: pat = 7'd3;
      8'h55: pat = 7'd9;
      8'h56: pat = 7'd17;
      8'h57: pat = 7'd11;
      8'h58: pat = 7'd25;
      8'h59: pat = 7'd27;
      8'h5A: pat = 7'd28;
      8'h30: pat = 7'd63;
      8'h31: pat = 7'd47;
      8'h32: pat = 7'd39;
      8'h33: pat = 7'd35;
      8'h34: pat = 7'd33;
      8'h35: pat = 7'd32;
      8'h36: pat = 7'd48;
      8'h37: pat = 7'd56;
      8'h38: pat = 7'd60;
      8'h39: pat = 7'd62;
      8'h2E: pat = 7'd85;
      8'h2C: pat = 7'd115;
      8'h3F: pat = 7'd76;
      8'h21: pat = 7'd107;
      8'h2F: pat = 7'd50;
      8'h2D: pat = 7'd97;
      8'h2B: pat = 7'd42;
      8'h3D: pat = 7'd49;
      8'h3A: pat = 7'd120;
      8'h3B: pat = 7'd106;
      8'h28: pat = 7'd54;
      8'h29: pat = 7'd109;
      8'h26: pat = 7'd40;
      8'h40: pat = 7'd90;
      8'h27: pat = 7'd94;
      8'h22: pat = 7'd82;
      8'h5F: pat = 7'd77;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage

FILE: src/morse_front.sv
module morse_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  morse_pkg::morse_in_t    in_word_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output morse_pkg::morse_entry_t q_entry_o
);
  import morse_pkg::*;

  logic                  halted_q, halted_d;
  logic                  accept;
  logic [7:0]            ch;
  logic [PatWidth-1:0]   pat;
  logic [LenWidth-1:0]   len;
  logic [MaxSymbols-1:0] syms;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    ch = in_word_i.char_code;
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      ch = ch - FoldOffset;
    end
  end

  assign pat = morse_lookup(ch);

  always_comb begin
    priority if (pat[6]) begin
      len = LenWidth'(6);
    end else if (pat[5]) begin
      len = LenWidth'(5);
    end else if (pat[4]) begin
      len = LenWidth'(4);
    end else if (pat[3]) begin
      len = LenWidth'(3);
    end else if (pat[2]) begin
      len = LenWidth'(2);
    end else begin
      len = LenWidth'(1);
    end
  end

  // The first symbol sits just below the marker bit.
  always_comb begin
    for (int k = 0; k < MaxSymbols; k++) begin
      if (LenWidth'(k) < len) begin
        syms[k] = pat[len - LenWidth'(k) - LenWidth'(1)];
      end else begin
        syms[k] = 1'b0;
      end
    end
  end

  assign q_entry_o.unsupported = (pat == '0);
  assign q_entry_o.len         = len;
  assign q_entry_o.syms        = syms;
  assign q_push_o              = accept && !halted_q;

  always_comb begin
    halted_d = halted_q;
    if (accept) begin
      if (halted_q) begin
        halted_d = !in_word_i.end_of_message;
      end else begin
        halted_d = (pat == '0) && !in_word_i.end_of_message;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
    end else begin
      halted_q <= halted_d;
    end
  end

endmodule

FILE: src/morse_queue.sv
module morse_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  morse_pkg::morse_entry_t push_entry_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output logic                    head_valid_o,
  output morse_pkg::morse_entry_t head_entry_o
);
  import morse_pkg::*;

  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth  = $clog2(Depth + 1);

  morse_entry_t         mem_q [Depth];
  logic [AddrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o       = (cnt_q == CntWidth'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_entry_o = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrWidth'(Depth - 1)) ? '0 : wr_ptr_q + AddrWidth'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrWidth'(Depth - 1)) ? '0 : rd_ptr_q + AddrWidth'(1);
    end
    cnt_d = cnt_q + CntWidth'(do_push) - CntWidth'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: src/morse_back.sv
module morse_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    head_valid_i,
  input  morse_pkg::morse_entry_t head_entry_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output morse_pkg::morse_out_t   out_word_o
);
  import morse_pkg::*;

  logic                out_valid_q, out_valid_d;
  morse_out_t          out_q, out_d;
  logic [LenWidth-1:0] idx_q, idx_d;
  logic                load;

  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        if (head_entry_i.unsupported) begin
          out_d = '{symbol: SymDot, unsupported: 1'b1, last_of_char: 1'b1};
          pop_o = 1'b1;
          idx_d = '0;
        end else if (idx_q < head_entry_i.len) begin
          out_d.symbol       = head_entry_i.syms[idx_q] ? SymDash : SymDot;
          out_d.unsupported  = 1'b0;
          out_d.last_of_char = 1'b0;
          idx_d = idx_q + LenWidth'(1);
        end else begin
          out_d = '{symbol: SymGap, unsupported: 1'b0, last_of_char: 1'b1};
          pop_o = 1'b1;
          idx_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

FILE: src/morse_encoder.sv
// Channel   Direction  Handshake               Word
// input     in         in_valid_i / in_stall_o  char_code, end_of_message
// output    out        out_valid_o / out_stall_i symbol, unsupported, last_of_char
//
// A character occupies the output for its symbols followed by one gap word.
// An unsupported character yields a single word marked unsupported; characters dropped while halted yield none there.
// Unstalled, the output register issues one word per cycle; input runs ahead by QueueDepth.
// Reset clears the halt flag, the queue and the output valid.
// Input stalls only while the queue is full.
module morse_encoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  morse_pkg::morse_in_t  in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output morse_pkg::morse_out_t out_word_o
);
  import morse_pkg::*;

  logic         q_push, q_full, q_pop, q_head_valid;
  morse_entry_t q_entry, q_head;

  morse_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  morse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_entry_o (q_head)
  );

  morse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_head_valid),
    .head_entry_i (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

endmodule
